/* hdl/command_word_signature_unit_defines.svh */
// Assertion macros shared by the command word signature unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef COMMAND_WORD_SIGNATURE_UNIT_DEFINES_SVH
`define COMMAND_WORD_SIGNATURE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cws_pkg.sv */
// Package for the command word signature unit: constants, types and CRC step functions.
// No dependencies.
package cws_pkg;

  localparam logic [7:0] POLY_FWD = 8'h31;
  localparam logic [7:0] POLY_REV = 8'h8C;
  localparam logic [7:0] SPACE_CH = 8'h20;
  localparam logic [7:0] NUL_CH   = 8'h00;

  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_PARSE_MODE = 3'd0;

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_WORD  = 2'd1,
    PH_DONE  = 2'd2,
    PH_EMPTY = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  crc_fwd;
    logic [7:0]  crc_rev;
    logic [4:0]  sum;
    logic [4:0]  len;
    logic [5:0]  first;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    phase:   PH_SKIP,
    crc_fwd: 8'h00,
    crc_rev: 8'h00,
    sum:     5'd0,
    len:     5'd0,
    first:   6'd0
  };

  // Forward CRC-8, MSB first.
  function automatic logic [7:0] crc_fwd_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ POLY_FWD) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Reflected CRC-8, LSB first.
  function automatic logic [7:0] crc_rev_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[7:1]} ^ POLY_REV) : {1'b0, c[7:1]};
    end
    return c;
  endfunction

endpackage

/* hdl/cws_if.sv */
// Valid/ready channel interfaces for the command word signature unit.
// Depends on nothing but plain logic types.
interface cws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_of_line;

  modport source (output valid, output char_byte, output last_of_line, input ready);
  modport sink   (input valid, input char_byte, input last_of_line, output ready);
endinterface

interface cws_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] command_id;
  logic        word_present;

  modport source (output valid, output command_id, output word_present, input ready);
  modport sink   (input valid, input command_id, input word_present, output ready);
endinterface

/* hdl/cws_step.sv */
// One byte of the word tracker: phase update, CRC and sum steps, and signature packing.
// Depends on cws_pkg.
module cws_step (
  input  cws_pkg::line_state_t line_i,
  input  logic [7:0]           char_i,
  input  logic                 parse_mode_i,
  output cws_pkg::line_state_t line_o,
  output logic                 present_o,
  output logic [31:0]          id_o
);

  logic is_nul;
  logic is_sep;
  logic ends;
  logic hash_en;
  logic first_ld;
  cws_pkg::phase_t phase_nxt;

  assign is_nul = (char_i == cws_pkg::NUL_CH);
  assign is_sep = parse_mode_i && (char_i == cws_pkg::SPACE_CH);
  assign ends   = is_nul || is_sep;

  // Next phase.
  always_comb begin
    case (line_i.phase)
      cws_pkg::PH_SKIP: begin
        if (is_nul) begin
          phase_nxt = cws_pkg::PH_EMPTY;
        end else if (!is_sep) begin
          phase_nxt = cws_pkg::PH_WORD;
        end else begin
          phase_nxt = cws_pkg::PH_SKIP;
        end
      end
      cws_pkg::PH_WORD: begin
        phase_nxt = ends ? cws_pkg::PH_DONE : cws_pkg::PH_WORD;
      end
      default: begin
        phase_nxt = line_i.phase;
      end
    endcase
  end

  // Hash controls for the current phase.
  always_comb begin
    case (line_i.phase)
      cws_pkg::PH_SKIP: begin
        hash_en  = !ends;
        first_ld = !ends;
      end
      cws_pkg::PH_WORD: begin
        hash_en  = !ends;
        first_ld = 1'b0;
      end
      default: begin
        hash_en  = 1'b0;
        first_ld = 1'b0;
      end
    endcase
  end

  always_comb begin
    line_o       = line_i;
    line_o.phase = phase_nxt;
    if (hash_en) begin
      line_o.crc_fwd = cws_pkg::crc_fwd_step(line_i.crc_fwd, char_i);
      line_o.crc_rev = cws_pkg::crc_rev_step(line_i.crc_rev, char_i);
      line_o.sum     = line_i.sum + char_i[4:0];
      line_o.len     = line_i.len + 5'd1;
    end
    if (first_ld) begin
      line_o.first = char_i[5:0];
    end
  end

  assign present_o = (phase_nxt == cws_pkg::PH_WORD) || (phase_nxt == cws_pkg::PH_DONE);
  assign id_o = present_o ?
                {line_o.first, line_o.len, line_o.sum, line_o.crc_fwd, line_o.crc_rev} :
                32'd0;

endmodule

/* hdl/command_word_signature_unit.sv */
// Top level of the command word signature unit: channel registers, line state, config port.
// Depends on cws_pkg, cws_if.sv, cws_step and command_word_signature_unit_defines.svh.
// The unit takes one byte beat per clock cycle, save while a line end waits on a full result
// register. Each beat is captured in an input register at the edge that accepts it, and from
// that register the single-pass hash logic (two 8-bit CRC steps, a 5-bit sum and a 5-bit
// count) updates the line state. When the beat carries last_of_line, the edge that processes
// it also writes the signature into the result register, which drives out_valid, so a final
// byte passes through the input register and then the result register. The result register
// parts the two channels: bytes keep flowing while a result waits, and the input side stalls
// only when a further line end arrives while the previous result is still untaken. After
// each line end the line state returns to its cleared value. The parse_mode register sits at
// byte address 0 of the APB-style port; it resets to 1 and should be written only while the
// unit is idle.
`include "command_word_signature_unit_defines.svh"

module command_word_signature_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  cws_in_if.sink                       in_bus,
  cws_out_if.source                    out_bus,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cws_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // Input register.
  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  // Line state and configuration.
  cws_pkg::line_state_t line_r;
  cws_pkg::line_state_t line_nxt;
  logic                 mode_r;

  // Result register.
  logic        out_v_r;
  logic [31:0] out_id_r;
  logic        out_wp_r;

  logic        proc;
  logic        present;
  logic [31:0] id;

  cws_step u_step (
    .line_i       (line_r),
    .char_i       (in_byte_r),
    .parse_mode_i (mode_r),
    .line_o       (line_nxt),
    .present_o    (present),
    .id_o         (id)
  );

  // A held beat is processed unless it ends a line and the result register is still full.
  assign proc         = in_v_r && (!in_last_r || !out_v_r || out_bus.ready);
  assign in_bus.ready = !in_v_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_byte_r <= in_bus.char_byte;
      in_last_r <= in_bus.last_of_line;
    end
  end

  // Line state: updated by every processed beat and cleared after a line end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= cws_pkg::LINE_CLEAR;
    end else if (proc) begin
      line_r <= in_last_r ? cws_pkg::LINE_CLEAR : line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last_r) begin
      out_id_r <= id;
      out_wp_r <= present;
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.command_id   = out_id_r;
  assign out_bus.word_present = out_wp_r;

  // Configuration port: no wait states, writes land on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (psel && penable && pwrite && (paddr == cws_pkg::REG_PARSE_MODE)) begin
      mode_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == cws_pkg::REG_PARSE_MODE) ? {31'd0, mode_r} : 32'd0;

  // A line end always leaves the line state cleared.
  `CWS_ASSERT_NEXT(a_clear_after_end, proc && in_last_r,
                   line_r == cws_pkg::LINE_CLEAR,
                   "line state not cleared after line end")

  // Nothing is counted while no word has started.
  `CWS_ASSERT_NOW(a_skip_empty,
                  (line_r.phase == cws_pkg::PH_SKIP) || (line_r.phase == cws_pkg::PH_EMPTY),
                  (line_r.len == 5'd0) && (line_r.sum == 5'd0),
                  "counts moved outside a word")

  // An absent word gives an all-zero signature.
  `CWS_ASSERT_NOW(a_empty_id_zero, out_v_r && !out_wp_r, out_id_r == 32'd0,
                  "empty word with non-zero signature")

  // A line end blocked by a full result register is held, not dropped.
  `CWS_ASSERT_NEXT(a_end_held, in_v_r && in_last_r && out_v_r && !out_bus.ready,
                   in_v_r && in_last_r && $stable(in_byte_r),
                   "blocked line end lost")

endmodule

/* verif/command_word_signature_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for command_word_signature_unit: byte beats in, signature beats out,
// each signature predicted here and compared field by field. Depends on cws_pkg, the channel
// interfaces of cws_if.sv and the unit itself.
module command_word_signature_unit_tb;

  // Share of cycles in which either side idles when gaps are allowed.
  localparam int IDLE_PCT      = 28;
  // Length of the deliberate receiver hold-off, in cycles.
  localparam int HOLD_CYCLES   = 250;
  // The unit raises out_valid once the final byte has passed its input and result registers;
  // the settle wait gives margin before the register is touched after a line that was left open.
  localparam int SETTLE_CYCLES = 6;

  typedef struct {
    logic [7:0] char_byte;
    logic       last_of_line;
  } line_byte_t;

  typedef struct {
    logic [31:0] command_id;
    logic        word_present;
  } signature_t;

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [cws_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  cws_in_if  in_bus ();
  cws_out_if out_bus ();

  command_word_signature_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Byte beats waiting to be offered, and the signatures the unit still owes us.
  line_byte_t bytes_to_send [$];
  signature_t signatures_due [$];

  int  bytes_queued       = 0;
  int  bytes_taken        = 0;
  int  signatures_checked = 0;
  int  mode_writes        = 0;
  int  fault_count        = 0;
  int  cfg_fault_count    = 0;

  // Stimulus controls: no_gaps switches off random idling on both sides; every increment of
  // hold_req asks the receiver for one long hold-off, which it counts out itself.
  bit  no_gaps  = 1'b0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  // Our own copy of the line state and of the parse_mode register.
  logic            mode_shadow = 1'b1;
  cws_pkg::phase_t line_phase;
  logic [7:0]      line_fwd;
  logic [7:0]      line_rev;
  logic [4:0]      line_sum;
  logic [4:0]      line_len;
  logic [5:0]      line_first;

  line_byte_t next_beat;

  // ---------------------------------------------------------------------------------------
  // Signature prediction
  // ---------------------------------------------------------------------------------------

  // Forward CRC-8 (polynomial 0x31), taken one data bit at a time from the top bit down.
  function automatic logic [7:0] crc8_msb_first(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ data[k];
      r  = {r[6:0], 1'b0};
      if (fb) r = r ^ cws_pkg::POLY_FWD;
    end
    return r;
  endfunction

  // Reflected CRC-8 (polynomial 0x8C), taken one data bit at a time from the bottom bit up.
  function automatic logic [7:0] crc8_lsb_first(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ data[k];
      r  = {1'b0, r[7:1]};
      if (fb) r = r ^ cws_pkg::POLY_REV;
    end
    return r;
  endfunction

  task automatic clear_line_state();
    line_phase = cws_pkg::PH_SKIP;
    line_fwd   = 8'h00;
    line_rev   = 8'h00;
    line_sum   = 5'd0;
    line_len   = 5'd0;
    line_first = 6'd0;
  endtask

  // Length and sum are kept in five bits, so both wrap on their own.
  task automatic fold_in(input logic [7:0] b);
    line_sum = line_sum + b[4:0];
    line_len = line_len + 5'd1;
    line_fwd = crc8_msb_first(line_fwd, b);
    line_rev = crc8_lsb_first(line_rev, b);
  endtask

  // Takes one accepted byte beat and, on the last byte of a line, files the signature the
  // unit must produce. The register is read afresh for every byte, as the unit does.
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic       word_break_space;
    signature_t sig;
    word_break_space = mode_shadow && (b == cws_pkg::SPACE_CH);
    case (line_phase)
      cws_pkg::PH_SKIP: begin
        if (b == cws_pkg::NUL_CH) begin
          line_phase = cws_pkg::PH_EMPTY;
        end else if (!word_break_space) begin
          line_first = b[5:0];
          fold_in(b);
          line_phase = cws_pkg::PH_WORD;
        end
      end
      cws_pkg::PH_WORD: begin
        if (b == cws_pkg::NUL_CH || word_break_space) line_phase = cws_pkg::PH_DONE;
        else fold_in(b);
      end
      default: begin
        // Once the word has ended, bytes are ignored until the end of the line.
      end
    endcase
    if (last) begin
      if (line_phase == cws_pkg::PH_WORD || line_phase == cws_pkg::PH_DONE) begin
        sig.command_id   = {line_first, line_len, line_sum, line_fwd, line_rev};
        sig.word_present = 1'b1;
      end else begin
        // No byte was hashed: the signature is all zeros, in either mode.
        sig.command_id   = 32'd0;
        sig.word_present = 1'b0;
      end
      signatures_due.push_back(sig);
      clear_line_state();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Clock and the run limit
  // ---------------------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout at %0t: %0d signatures still outstanding", $realtime,
             signatures_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Byte driver: offers queued beats, holds a beat steady until it is taken, and predicts
  // at the very edge on which the unit accepts it.
  // ---------------------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid        <= 1'b0;
      in_bus.char_byte    <= '0;
      in_bus.last_of_line <= 1'b0;
      clear_line_state();
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        absorb_byte(in_bus.char_byte, in_bus.last_of_line);
        bytes_taken++;
      end
      // A new beat may only be put up once the current one has gone.
      if (!in_bus.valid || in_bus.ready) begin
        if (bytes_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          next_beat = bytes_to_send.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.char_byte    <= next_beat.char_byte;
          in_bus.last_of_line <= next_beat.last_of_line;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result monitor: checks each signature beat against the oldest prediction and drives the
  // receiver's ready, including the long hold-off that fills the unit up.
  // ---------------------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (signatures_due.size() == 0) begin
          $display("%0t: signature beat %h (word_present %b) arrived with none expected",
                   $realtime, out_bus.command_id, out_bus.word_present);
          fault_count++;
        end else begin
          if (out_bus.command_id !== signatures_due[0].command_id) begin
            $display("%0t: command_id expected %h, got %h", $realtime,
                     signatures_due[0].command_id, out_bus.command_id);
            fault_count++;
          end
          if (out_bus.word_present !== signatures_due[0].word_present) begin
            $display("%0t: word_present expected %b, got %b", $realtime,
                     signatures_due[0].word_present, out_bus.word_present);
            fault_count++;
          end
          void'(signatures_due.pop_front());
          signatures_checked++;
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  task automatic queue_beat(input logic [7:0] b, input logic last);
    bytes_to_send.push_back(line_byte_t'{b, last});
    bytes_queued++;
  endtask

  // Junk bytes lean towards NUL and space, the two bytes that steer the line state.
  function automatic logic [7:0] noise_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return cws_pkg::NUL_CH;
    if (r < 40) return cws_pkg::SPACE_CH;
    return 8'($urandom_range(255, 0));
  endfunction

  // Queues whole lines until about quota bytes are waiting. Most lines are well formed for
  // the given mode (leading spaces, a word, an optional terminator and trailing junk); the
  // rest are short runs of junk. brief keeps every line to a few bytes so that line ends come
  // thick and fast. Half the time a line is left open at the end, so that the next register
  // setting applies in the middle of it.
  task automatic queue_lines(input logic pm, input int quota, input bit brief);
    line_byte_t line [$];
    int         pushed;
    int         n;
    logic [7:0] c;
    pushed = 0;
    while (pushed < quota) begin
      line.delete();
      if ($urandom_range(99) < 25) begin
        n = $urandom_range(brief ? 2 : 6, 1);
        repeat (n) line.push_back(line_byte_t'{noise_byte(), 1'b0});
      end else begin
        repeat ($urandom_range(brief ? 1 : 3, 0)) begin
          line.push_back(line_byte_t'{cws_pkg::SPACE_CH, 1'b0});
        end
        if (brief) n = $urandom_range(2, 1);
        else if ($urandom_range(99) < 6) n = $urandom_range(40, 28);
        else n = $urandom_range(8, 1);
        repeat (n) begin
          if (!pm && $urandom_range(99) < 20) begin
            c = cws_pkg::SPACE_CH;
          end else begin
            do c = 8'($urandom_range(255, 1)); while (pm && c == cws_pkg::SPACE_CH);
          end
          line.push_back(line_byte_t'{c, 1'b0});
        end
        case ($urandom_range(2, 0))
          1: line.push_back(line_byte_t'{cws_pkg::SPACE_CH, 1'b0});
          2: line.push_back(line_byte_t'{cws_pkg::NUL_CH, 1'b0});
          default: begin
          end
        endcase
        if (!brief) repeat ($urandom_range(3, 0)) line.push_back(line_byte_t'{noise_byte(), 1'b0});
      end
      line[line.size()-1].last_of_line = 1'b1;
      foreach (line[k]) queue_beat(line[k].char_byte, line[k].last_of_line);
      pushed += line.size();
    end
    if ($urandom_range(1, 0) == 1) begin
      repeat ($urandom_range(3, 1)) queue_beat(noise_byte(), 1'b0);
    end
  endtask

  // Waits until every queued beat has been taken and every signature has come back, then
  // lets the unit settle, since an open line gives no result to wait for.
  task automatic wait_until_quiet();
    do @(posedge clk);
    while (bytes_taken != bytes_queued || signatures_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes parse_mode through the configuration port and reads it straight back. The read's
  // setup cycle follows on from the write's access cycle with psel kept high.
  task automatic set_parse_mode(input logic v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cws_pkg::REG_PARSE_MODE;
    pwdata  <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mode_shadow = v;
    mode_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== v) begin
      $display("%0t: parse_mode read back expected %b, got %b", $realtime, v, prdata[0]);
      cfg_fault_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    // The configuration port and reset are known from time zero.
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Parse mode, the reset setting. A lone 0xFF is a word of one byte; a lone NUL and a
    // lone space are empty lines; then leading spaces are skipped and a space ends the word,
    // a NUL ends a word with junk after it, and a byte with its top bit set stands alone.
    queue_beat(8'hFF, 1'b1);
    queue_beat(cws_pkg::NUL_CH, 1'b1);
    queue_beat(cws_pkg::SPACE_CH, 1'b1);
    queue_beat(cws_pkg::SPACE_CH, 1'b0);
    queue_beat("A", 1'b0);
    queue_beat(cws_pkg::SPACE_CH, 1'b0);
    queue_beat("Z", 1'b1);
    queue_beat(8'h01, 1'b0);
    queue_beat(cws_pkg::NUL_CH, 1'b0);
    queue_beat(8'h7F, 1'b1);
    queue_beat(8'h80, 1'b1);
    wait_until_quiet();

    // Register mode: spaces are hashed like any byte, a lone space is a word, a lone NUL is
    // still an empty line, and a NUL ends the word.
    set_parse_mode(1'b0);
    queue_beat(cws_pkg::SPACE_CH, 1'b0);
    queue_beat("a", 1'b0);
    queue_beat(cws_pkg::SPACE_CH, 1'b0);
    queue_beat("b", 1'b1);
    queue_beat(cws_pkg::NUL_CH, 1'b1);
    queue_beat(cws_pkg::SPACE_CH, 1'b1);
    queue_beat(8'h80, 1'b0);
    queue_beat(cws_pkg::NUL_CH, 1'b0);
    queue_beat(8'h55, 1'b1);

    // Mode change within a line: the leading space is hashed in register mode, then after
    // the switch the next space closes the word.
    queue_beat(cws_pkg::SPACE_CH, 1'b0);
    queue_beat("k", 1'b0);
    wait_until_quiet();
    set_parse_mode(1'b1);
    queue_beat(cws_pkg::SPACE_CH, 1'b0);
    queue_beat("m", 1'b1);
    wait_until_quiet();

    // Random parse-mode lines, with the sender pausing half way until all results are in.
    queue_lines(1'b1, 65, 1'b0);
    wait_until_quiet();
    queue_lines(1'b1, 65, 1'b0);
    wait_until_quiet();

    // Short register-mode lines while the receiver holds off for a long stretch: the result
    // register fills and the unit must stall its input until the hold-off ends.
    set_parse_mode(1'b0);
    hold_req <= hold_req + 1;
    queue_lines(1'b0, 100, 1'b1);
    wait_until_quiet();

    queue_lines(1'b0, 115, 1'b0);
    wait_until_quiet();

    // A long stretch with neither side idling, in parse mode.
    set_parse_mode(1'b1);
    no_gaps <= 1'b1;
    queue_lines(1'b1, 115, 1'b0);
    wait_until_quiet();
    no_gaps <= 1'b0;

    set_parse_mode(1'b0);
    queue_lines(1'b0, 115, 1'b0);
    wait_until_quiet();

    set_parse_mode(1'b1);
    queue_lines(1'b1, 115, 1'b0);
    wait_until_quiet();

    $display("Run covered %0d byte beats and %0d signatures over %0d mode writes,",
             bytes_taken, signatures_checked, mode_writes);
    $display("both modes, mid-line mode switches, wrapping long words and a full-output stall.");
    if (fault_count + cfg_fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found", fault_count + cfg_fault_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/cws_pkg.sv
hdl/cws_if.sv
hdl/cws_step.sv
hdl/command_word_signature_unit.sv
verif/command_word_signature_unit_tb.sv
